/* design/lzsd_pkg.sv */
// ----------------------------------------------------------------------------
// lzsd_pkg: shared constants and types of the LZSS stream decompressor
// Window size, count width, match length encoding and the history write port.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
    localparam int COUNT_BITS   = 24;
    localparam int OUT_COUNT_W  = 24;
    localparam int BYTE_W       = 8;
    localparam int FLAG_W       = 9;
    localparam int LEN_FIELD_W  = 4;
    localparam int MATCH_MIN    = 3;
    localparam int MATCH_MAX    = (1 << LEN_FIELD_W) - 1 + MATCH_MIN;
    localparam int LEFT_W       = $clog2(MATCH_MAX + 1);
    localparam int OFF_HI_W     = WIN_BITS - BYTE_W;

    localparam logic [FLAG_W-1:0]     FLAG_EMPTY = FLAG_W'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    typedef struct packed {
        logic                en;
        logic [WIN_BITS-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } t_hist_wr;

endpackage

/* design/lzsd_if.sv */
// ----------------------------------------------------------------------------
// lzsd_if: stream channels of the LZSS stream decompressor
// Compressed input channel and decoded output channel, valid/ready.
// ----------------------------------------------------------------------------
interface lzsd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lzsd_pkg::BYTE_W-1:0] in_byte;
    logic                      frame_end;

    modport source (output valid, output in_byte, output frame_end, input ready);
    modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface lzsd_out_if;
    logic                             valid;
    logic                             ready;
    logic [lzsd_pkg::BYTE_W-1:0]      out_byte;
    logic                             run_last;
    logic [lzsd_pkg::OUT_COUNT_W-1:0] out_count;

    modport source (output valid, output out_byte, output run_last, output out_count,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input out_count,
                    output ready);
endinterface

/* design/lzss_stream_decompressor.sv */
// ----------------------------------------------------------------------------
// lzss_stream_decompressor: LZSS decoder with a 4096-byte history window
// Parses flag, literal and match bytes and replays matches from history.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one compressed byte per beat (in_byte, frame_end). o_out
//   carries one decoded byte per beat with run_last, set on the last byte
//   that an input beat produced, and out_count, the saturating byte count
//   of the current frame.
//   Flag bytes and first match bytes give no output. A literal is loaded
//   into the output register and shows there in the cycle after it is
//   accepted. A second match byte of length L (3..18) holds the input
//   until the match is replayed: it is taken, the first history byte is
//   fetched through the registered single read port, then each further
//   fetch overlaps the emission of the byte before it.
//   A new beat is taken only while no match replay is running and the
//   output register is free or being drained this cycle.
//   Reset: synchronous, active low. The parser expects a flag byte and the
//   count is zero. The history is not swept: a fill mark (write position
//   plus a wrapped bit) makes entries never written read as zero, so the
//   block is ready in the first cycle after reset.
//   Receiver stall: the output register holds its beat; a running match
//   halts with its fetched byte parked until the register frees up.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzsd_in_if.sink     i_in,
    lzsd_out_if.source  o_out
);

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_ITEM = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    // parser state
    t_phase                                r_phase,     n_phase;
    logic [lzsd_pkg::FLAG_W-1:0]           r_flag,      n_flag;
    logic [lzsd_pkg::BYTE_W-1:0]           r_match_low, n_match_low;
    logic [lzsd_pkg::COUNT_BITS-1:0]       r_count,     n_count;
    // history fill mark
    logic [lzsd_pkg::WIN_BITS-1:0]         r_wr_pos,    n_wr_pos;
    logic                                  r_wrapped,   n_wrapped;
    // match replay engine
    logic [lzsd_pkg::WIN_BITS-1:0]         r_src,       n_src;
    logic [lzsd_pkg::LEFT_W-1:0]           r_left,      n_left;
    logic                                  r_pend,      n_pend;
    logic                                  r_rd_ok,     n_rd_ok;
    logic                                  r_fend_pend, n_fend_pend;
    // output register
    logic                                  r_out_valid, n_out_valid;
    logic [lzsd_pkg::BYTE_W-1:0]           r_out_byte,  n_out_byte;
    logic                                  r_out_last,  n_out_last;
    logic [lzsd_pkg::OUT_COUNT_W-1:0]      r_out_count, n_out_count;

    logic                                  out_free;
    logic                                  busy;
    logic                                  in_ready;
    logic                                  in_acc;
    logic                                  emit_m;
    logic                                  issue;
    logic                                  lit;
    logic [lzsd_pkg::COUNT_BITS-1:0]       count_inc;
    logic [lzsd_pkg::BYTE_W-1:0]           hist_q;
    logic [lzsd_pkg::BYTE_W-1:0]           m_byte;
    lzsd_pkg::t_hist_wr                    hist_wr;

    lzsd_hist u_hist (
        .i_clk     (i_clk),
        .i_wr      (hist_wr),
        .i_rd_en   (issue),
        .i_rd_addr (r_src),
        .o_rd_data (hist_q)
    );

    // Output register drains or is empty: a new byte may be loaded.
    assign out_free  = !r_out_valid || o_out.ready;
    assign busy      = r_pend || (r_left != '0);
    assign in_ready  = !busy && out_free;
    assign in_acc    = i_in.valid && in_ready;
    // Emit the parked match byte; fetch the next one alongside it.
    assign emit_m    = r_pend && out_free;
    assign issue     = (r_left != '0) && (!r_pend || emit_m);
    assign count_inc = (r_count == lzsd_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    // Entries never written since reset read as zero.
    assign m_byte    = r_rd_ok ? hist_q : '0;

    always_comb begin
        n_phase     = r_phase;
        n_flag      = r_flag;
        n_match_low = r_match_low;
        n_count     = r_count;
        n_src       = r_src;
        n_left      = r_left;
        n_pend      = r_pend;
        n_rd_ok     = r_rd_ok;
        n_fend_pend = r_fend_pend;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_count = r_out_count;
        lit         = 1'b0;

        // Parse one compressed byte.
        if (in_acc) begin
            case (r_phase)
                PH_ITEM: begin
                    n_flag = r_flag >> 1;
                    if (r_flag[0]) begin
                        lit     = 1'b1;
                        n_phase = (n_flag == lzsd_pkg::FLAG_EMPTY) ? PH_FLAG : PH_ITEM;
                    end else begin
                        n_match_low = i_in.in_byte;
                        n_phase     = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    n_src       = r_wr_pos
                                + {i_in.in_byte[lzsd_pkg::OFF_HI_W-1:0], r_match_low};
                    n_left      = lzsd_pkg::LEFT_W'(i_in.in_byte[lzsd_pkg::BYTE_W-1 -: lzsd_pkg::LEN_FIELD_W])
                                + lzsd_pkg::LEFT_W'(lzsd_pkg::MATCH_MIN);
                    n_fend_pend = i_in.frame_end;
                    n_phase     = (r_flag == lzsd_pkg::FLAG_EMPTY) ? PH_FLAG : PH_ITEM;
                end
                default: begin
                    // expect flag byte, also the unused phase code
                    n_flag  = {1'b1, i_in.in_byte};
                    n_phase = PH_ITEM;
                end
            endcase

            if (lit) begin
                n_count = i_in.frame_end ? '0 : count_inc;
            end else if (i_in.frame_end && (r_phase != PH_HIGH)) begin
                n_count = '0;
            end

            // Frame end: drop parse state now; a match defers its count clear.
            if (i_in.frame_end) begin
                n_phase     = PH_FLAG;
                n_flag      = lzsd_pkg::FLAG_EMPTY;
                n_match_low = '0;
            end
        end

        if (emit_m) begin
            n_count = ((r_left == '0) && r_fend_pend) ? '0 : count_inc;
            if (r_left == '0) begin
                n_fend_pend = 1'b0;
            end
        end

        // Output register: load a literal or a replayed byte, else drain.
        if (lit) begin
            n_out_valid = 1'b1;
            n_out_byte  = i_in.in_byte;
            n_out_last  = 1'b1;
            n_out_count = lzsd_pkg::OUT_COUNT_W'(count_inc);
        end else if (emit_m) begin
            n_out_valid = 1'b1;
            n_out_byte  = m_byte;
            n_out_last  = (r_left == '0);
            n_out_count = lzsd_pkg::OUT_COUNT_W'(count_inc);
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // History write: every decoded byte goes to the window.
        hist_wr.en   = lit || emit_m;
        hist_wr.addr = r_wr_pos;
        hist_wr.data = lit ? i_in.in_byte : m_byte;
        n_wr_pos     = r_wr_pos + lzsd_pkg::WIN_BITS'(hist_wr.en);
        n_wrapped    = r_wrapped || (hist_wr.en && (r_wr_pos == '1));

        // Fetch the next match byte; the fill mark includes this cycle's write.
        if (issue) begin
            n_src   = r_src + 1'b1;
            n_left  = r_left - 1'b1;
            n_pend  = 1'b1;
            n_rd_ok = n_wrapped || (r_src < n_wr_pos);
        end else if (emit_m) begin
            n_pend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_flag      <= lzsd_pkg::FLAG_EMPTY;
            r_match_low <= '0;
            r_count     <= '0;
            r_wr_pos    <= '0;
            r_wrapped   <= 1'b0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_fend_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_flag      <= n_flag;
            r_match_low <= n_match_low;
            r_count     <= n_count;
            r_wr_pos    <= n_wr_pos;
            r_wrapped   <= n_wrapped;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_fend_pend <= n_fend_pend;
            r_out_valid <= n_out_valid;
        end
        r_src       <= n_src;
        r_rd_ok     <= n_rd_ok;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_count <= n_out_count;
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.run_last  = r_out_last;
    assign o_out.out_count = r_out_count;

    // No compressed byte is taken while a match replay is in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!r_pend && (r_left == '0)))
        else $error("input accepted during match replay");

    // Each history write advances the write position by one.
    a_wr_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_wr.en |=> (r_wr_pos == $past(r_wr_pos) + 1'b1))
        else $error("write position did not advance");

    // The last replayed byte leaves the engine idle.
    a_match_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_m && (r_left == '0)) |=> (!r_pend && (r_left == '0) && o_out.run_last))
        else $error("match replay did not finish with last byte");

    // The fill mark never goes back once the window has wrapped.
    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrapped |=> r_wrapped)
        else $error("wrapped mark cleared");

endmodule

/* design/lzsd_hist.sv */
// ----------------------------------------------------------------------------
// lzsd_hist: history window memory
// One write and one read port, registered read data, and a bypass of a
// write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module lzsd_hist (
    input  logic                                i_clk,
    input  lzsd_pkg::t_hist_wr                  i_wr,
    input  logic                                i_rd_en,
    input  logic [lzsd_pkg::WIN_BITS-1:0]       i_rd_addr,
    output logic [lzsd_pkg::BYTE_W-1:0]         o_rd_data
);

    logic [lzsd_pkg::BYTE_W-1:0] r_mem [lzsd_pkg::WINDOW_DEPTH];
    logic [lzsd_pkg::BYTE_W-1:0] r_q;
    logic [lzsd_pkg::BYTE_W-1:0] r_fwd_data;
    logic                        r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd      <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of lzss_stream_decompressor
// Feeds compressed beats through the input channel and decodes the same
// stream in a local model of the parser and history window. Every output
// beat is checked field by field, oldest first, under several idle and
// stall mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzsd_pkg::*;

    // Cap the run far above the slowest legal run: about 150 beats, each up
    // to 18 decoded bytes, each byte waiting out long receiver stalls.
    localparam int TIMEOUT_CYCLES   = 200000;
    // Let a beat that yields no output (flag byte, first match byte) finish
    // inside the block before the next phase starts.
    localparam int SETTLE_CYCLES    = 40;
    localparam int BEATS_PER_PHASE  = 20;
    localparam int NUM_PHASES       = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              frame_end;
    } comp_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0]      out_byte;
        logic                   run_last;
        logic [OUT_COUNT_W-1:0] out_count;
    } decoded_t;

    typedef enum logic [1:0] {
        PS_FLAG     = 2'd0,
        PS_TOKEN    = 2'd1,
        PS_MATCH_HI = 2'd2
    } parse_state_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lzsd_in_if  in_ch ();
    lzsd_out_if out_ch ();

    lzss_stream_decompressor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Beats still to be sent, and decoded bytes still to be seen.
    comp_beat_t  pending_q[$];
    decoded_t    decoded_q[$];
    comp_beat_t  drv_beat;
    decoded_t    got_byte;
    decoded_t    want_byte;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_cnt;
    int          err_cnt;
    int          beats_in;
    int          bytes_out;
    int          match_cnt;
    int          fend_cnt;

    // Local copy of the decoder state.
    logic [BYTE_W-1:0]     hist_mem [WINDOW_DEPTH];
    logic [WIN_BITS-1:0]   hist_wp;
    logic [FLAG_W-1:0]     flag_bits;
    parse_state_t          parse_st;
    logic [BYTE_W-1:0]     match_lo_byte;
    logic [COUNT_BITS-1:0] frame_bytes;

    // ------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Store one decoded byte in the window, bump the saturating frame
    // count and queue the byte as the next expected output beat.
    task automatic store_decoded(input logic [BYTE_W-1:0] b, input logic last);
        hist_mem[hist_wp] = b;
        hist_wp = hist_wp + 1'b1;
        if (frame_bytes != COUNT_MAX)
            frame_bytes = frame_bytes + 1'b1;
        decoded_q.push_back('{out_byte: b, run_last: last,
                              out_count: frame_bytes[OUT_COUNT_W-1:0]});
    endtask

    // Advance the parser by one accepted compressed beat.
    task automatic decode_beat(input logic [BYTE_W-1:0] b, input logic fend);
        logic                  tok_is_lit;
        logic [WIN_BITS-1:0]   offs;
        logic [WIN_BITS-1:0]   src;
        int unsigned           len;
        case (parse_st)
            PS_TOKEN: begin
                // Consume flags least significant bit first.
                tok_is_lit = flag_bits[0];
                flag_bits  = flag_bits >> 1;
                if (tok_is_lit) begin
                    store_decoded(b, 1'b1);
                    parse_st = (flag_bits == FLAG_EMPTY) ? PS_FLAG : PS_TOKEN;
                end else begin
                    match_lo_byte = b;
                    parse_st      = PS_MATCH_HI;
                end
            end
            PS_MATCH_HI: begin
                offs = {b[OFF_HI_W-1:0], match_lo_byte};
                len  = int'(b[BYTE_W-1:BYTE_W-LEN_FIELD_W]) + MATCH_MIN;
                match_cnt++;
                // Copy byte by byte so an overlapping match repeats itself.
                for (int i = 0; i < len; i++) begin
                    src = hist_wp + offs;
                    store_decoded(hist_mem[src], i == len - 1);
                end
                parse_st = (flag_bits == FLAG_EMPTY) ? PS_FLAG : PS_TOKEN;
            end
            default: begin
                // A sentinel bit on top marks when all eight flags are used.
                flag_bits = {1'b1, b};
                parse_st  = PS_TOKEN;
            end
        endcase
        if (fend) begin
            // Drop any half-read match; keep history and write position.
            parse_st      = PS_FLAG;
            flag_bits     = FLAG_EMPTY;
            match_lo_byte = '0;
            frame_bytes   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [BYTE_W-1:0] b, input logic fend);
        pending_q.push_back('{in_byte: b, frame_end: fend});
    endtask

    // Short directed stream: field extremes, every token kind, reads of
    // never-written history, and frame ends at each parse position.
    task automatic queue_directed();
        // All-match flag byte. First match: offset 0 (distance 4096),
        // length 18, before anything was decoded: reads zeros.
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hF0, 1'b0);
        // Frame end on a first match byte: no output, match dropped.
        push_beat(8'h12, 1'b1);
        // All-literal flag byte with extreme literal values.
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h01, 1'b0);
        push_beat(8'h80, 1'b0);
        push_beat(8'h7F, 1'b0);
        push_beat(8'hFE, 1'b0);
        push_beat(8'h55, 1'b0);
        push_beat(8'hAA, 1'b0);
        // Match, literal, match: distance 1 length 3 (repeat last byte),
        // then distance 2 length 18 (overlapping pair repeat).
        push_beat(8'h02, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h0F, 1'b0);
        push_beat(8'h3C, 1'b0);
        push_beat(8'hFE, 1'b0);
        push_beat(8'hFF, 1'b0);
        // Flags left over: frame end on a first match byte mid-group.
        push_beat(8'h5A, 1'b1);
        // Frame end on a flag byte: no output.
        push_beat(8'hA5, 1'b1);
        // Frame end on a literal: count restarts after it.
        push_beat(8'h01, 1'b0);
        push_beat(8'h99, 1'b1);
        // Frame end on a second match byte: distance 4096, length 3.
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b1);
    endtask

    // Random stream: mostly well-formed groups (flag byte plus its tokens)
    // with random content, some cut short by a frame end, plus short bursts
    // of noise closed by a frame end to bring the parser back in step.
    task automatic queue_random_beats(input int n);
        comp_beat_t          grp_q[$];
        logic [BYTE_W-1:0]   flags;
        logic [WIN_BITS-1:0] offs;
        int unsigned         back_dist;
        int                  sent;
        int                  burst;
        int                  cut;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 4);
                for (int j = 0; j < burst; j++)
                    push_beat(BYTE_W'($urandom), j == burst - 1);
                sent += burst;
            end else begin
                grp_q.delete();
                flags = BYTE_W'($urandom);
                grp_q.push_back('{in_byte: flags, frame_end: 1'b0});
                for (int k = 0; k < 8; k++) begin
                    if (flags[k]) begin
                        grp_q.push_back('{in_byte: BYTE_W'($urandom), frame_end: 1'b0});
                    end else begin
                        // Favor short distances so copies hit fresh bytes
                        // and often overlap themselves.
                        case ($urandom_range(0, 3))
                            0, 1:    back_dist = $urandom_range(1, 24);
                            2:       back_dist = $urandom_range(1, 300);
                            default: back_dist = $urandom_range(1, WINDOW_DEPTH);
                        endcase
                        offs = WIN_BITS'(WINDOW_DEPTH - back_dist);
                        grp_q.push_back('{in_byte: offs[BYTE_W-1:0], frame_end: 1'b0});
                        grp_q.push_back('{in_byte: {4'($urandom), offs[WIN_BITS-1:BYTE_W]},
                                          frame_end: 1'b0});
                    end
                end
                cut = grp_q.size() - 1;
                if ($urandom_range(0, 5) == 0) begin
                    cut = $urandom_range(0, grp_q.size() - 1);
                    grp_q[cut].frame_end = 1'b1;
                end else if ($urandom_range(0, 3) == 0) begin
                    grp_q[cut].frame_end = 1'b1;
                end
                for (int j = 0; j <= cut; j++)
                    pending_q.push_back(grp_q[j]);
                sent += cut + 1;
            end
        end
    endtask

    // Hold the sender until every queued beat is taken and every expected
    // byte has come out, then let any silent beat finish inside the block.
    task automatic drain_and_settle();
        while (pending_q.size() != 0 || in_ch.valid || decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: take the next pending beat once the last one is gone
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_beat = pending_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.in_byte   <= drv_beat.in_byte;
                in_ch.frame_end <= drv_beat.frame_end;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: stall at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input beats, check output beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                beats_in++;
                if (in_ch.frame_end)
                    fend_cnt++;
                decode_beat(in_ch.in_byte, in_ch.frame_end);
            end
            if (out_ch.valid && out_ch.ready) begin
                got_byte = '{out_byte: out_ch.out_byte, run_last: out_ch.run_last,
                             out_count: out_ch.out_count};
                bytes_out++;
                if (decoded_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output beat: expected none, actual %h",
                             $realtime, got_byte);
                end else begin
                    want_byte = decoded_q.pop_front();
                    if (got_byte.out_byte !== want_byte.out_byte) begin
                        err_cnt++;
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $realtime, want_byte.out_byte, got_byte.out_byte);
                    end
                    if (got_byte.run_last !== want_byte.run_last) begin
                        err_cnt++;
                        $display("%0t: run_last mismatch: expected %b, actual %b",
                                 $realtime, want_byte.run_last, got_byte.run_last);
                    end
                    if (got_byte.out_count !== want_byte.out_count) begin
                        err_cnt++;
                        $display("%0t: out_count mismatch: expected %0d, actual %0d",
                                 $realtime, want_byte.out_count, got_byte.out_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("%0t: timeout, %0d bytes still expected", $realtime, decoded_q.size());
            $display("lzss_stream_decompressor test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = '0;
        in_ch.frame_end  = 1'b0;
        out_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        cycle_cnt        = 0;
        err_cnt          = 0;
        beats_in         = 0;
        bytes_out        = 0;
        match_cnt        = 0;
        fend_cnt         = 0;
        // History starts cleared, parser expects a flag byte.
        for (int i = 0; i < WINDOW_DEPTH; i++)
            hist_mem[i] = '0;
        hist_wp       = '0;
        flag_bits     = FLAG_EMPTY;
        parse_st      = PS_FLAG;
        match_lo_byte = '0;
        frame_bytes   = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_directed();
        drain_and_settle();

        // Random phases: no idling, sender idle, receiver stall, both light.
        // Each phase ends with the sender held until the block is empty.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            queue_random_beats(BEATS_PER_PHASE);
            drain_and_settle();
        end

        $display("Decoded %0d bytes from %0d compressed beats (%0d matches, %0d frame ends)",
                 bytes_out, beats_in, match_cnt, fend_cnt);
        $display("Idle mixes run: none, sender 64%%, receiver 64%%, both 8%%; %0d errors",
                 err_cnt);
        if (err_cnt == 0)
            $display("lzss_stream_decompressor test passed");
        else
            $display("lzss_stream_decompressor test failed");
        $finish;
    end

endmodule
